@@ hdl/swm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  // Positions are kept modulo 2^16.
  localparam int POS_BITS = 16;

  // Configuration port.
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam int WLEN_BITS     = 7;

  // Register index, taken from paddr[2].
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  // Control that every cell of the candidate chain sees in one cycle.
  typedef struct packed {
    logic step;   // a transaction is taken: compare, drop back entries, insert
    logic shift;  // every cell takes its right neighbor's contents
    logic clear;  // start of a new sequence: all entries are treated as empty
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/swm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One candidate slot. The slot either keeps its own entry or takes the one
// from its right neighbor, then keeps it only if it is not smaller than the
// new sample. The new sample lands in the first slot that drops its entry.
module swm_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  swm_pkg::cell_ctrl_t           ctrl,
  input  wire  signed [SAMPLE_BITS-1:0]       sample_i,
  input  wire         [swm_pkg::POS_BITS-1:0] pos_i,
  input  wire                                 keep_left_i,
  input  wire                                 right_valid_i,
  input  wire  signed [SAMPLE_BITS-1:0]       right_value_i,
  input  wire         [swm_pkg::POS_BITS-1:0] right_pos_i,
  output logic                                valid_o,
  output logic signed [SAMPLE_BITS-1:0]       value_o,
  output logic        [swm_pkg::POS_BITS-1:0] pos_o,
  output logic                                keep_o
);

  logic                                valid_r;
  logic                                valid_nxt;
  logic signed [SAMPLE_BITS-1:0]       value_r;
  logic signed [SAMPLE_BITS-1:0]       value_nxt;
  logic        [swm_pkg::POS_BITS-1:0] pos_r;
  logic        [swm_pkg::POS_BITS-1:0] pos_nxt;
  logic                                src_valid;
  logic signed [SAMPLE_BITS-1:0]       src_value;
  logic        [swm_pkg::POS_BITS-1:0] src_pos;
  logic                                keep;
  logic                                insert;

  always_comb begin
    src_valid = ctrl.shift ? right_valid_i : valid_r;
    src_value = ctrl.shift ? right_value_i : value_r;
    src_pos   = ctrl.shift ? right_pos_i   : pos_r;
    if (ctrl.clear) begin
      src_valid = 1'b0;
    end
    keep   = src_valid && (src_value >= sample_i);
    insert = ctrl.step && keep_left_i && !keep;
    if (ctrl.step) begin
      valid_nxt = keep || insert;
      value_nxt = insert ? sample_i : src_value;
      pos_nxt   = insert ? pos_i    : src_pos;
    end else begin
      valid_nxt = src_valid;
      value_nxt = src_value;
      pos_nxt   = src_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pos_r   <= pos_nxt;
  end

  assign valid_o = valid_r;
  assign value_o = value_r;
  assign pos_o   = pos_r;
  assign keep_o  = keep;

endmodule

`default_nettype wire

@@ hdl/swm_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result buffer between the candidate chain and the output port.
module swm_out_fifo #(
  parameter int WIDTH = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] data_i,
  output logic             space_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  wire              ready_i
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             pop;

  always_comb begin
    pop        = valid_o && ready_i;
    wr_ptr_nxt = push_i ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  assign valid_o = (cnt_r != 2'd0);
  assign data_o  = mem_r[rd_ptr_r];
  assign space_o = (cnt_r != 2'd2);

endmodule

`default_nettype wire

@@ hdl/sliding_window_maximum_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window maximum over a stream of signed samples. The unit keeps a
// chain of WINDOW_MAX candidate cells holding a non-increasing list of
// samples with their 16-bit positions, the front cell being the oldest and
// largest. Each input transaction drops a stale front candidate, drops every
// back candidate smaller than the new sample and appends the sample, all in
// one update; once window_length samples of the current sequence have been
// taken, the front value is delivered as a result transaction through the
// result buffer. The sustained rate is one sample per clock while in_ready
// stays high. When window_length is lowered in the middle of a sequence,
// several front candidates may be stale at once; each one beyond the first
// costs an extra shift of the chain, during which in_ready is low. Results
// pass through a two-entry buffer, so the input keeps flowing while a
// result waits; the buffer drops in_ready only when both entries are full. A
// window_length of zero acts as one and a value above WINDOW_MAX acts as
// WINDOW_MAX. Setting in_sequence_start on a sample restarts the window
// with that sample. The register window_length sits at byte address 0,
// resets to 1 and may be rewritten only while no transaction is in flight.
module sliding_window_maximum_unit #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                     clk,
  input  wire                                     rst_n,

  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire  signed [SAMPLE_BITS-1:0]           in_sample,
  input  wire                                     in_sequence_start,

  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [SAMPLE_BITS-1:0]           out_window_max,

  input  wire                                     psel,
  input  wire                                     penable,
  input  wire                                     pwrite,
  input  wire         [swm_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire         [swm_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic        [swm_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                    pready
);

  // Counters that must hold WINDOW_MAX itself.
  localparam int CntBits = $clog2(WINDOW_MAX + 1);
  localparam int PosBits = swm_pkg::POS_BITS;

  // Configuration register.
  logic [swm_pkg::WLEN_BITS-1:0] wlen_r;
  logic [swm_pkg::WLEN_BITS-1:0] wlen_nxt;
  logic                          cfg_write;

  // Sequence state.
  logic [PosBits-1:0] pos_r;
  logic [PosBits-1:0] pos_nxt;
  logic [CntBits-1:0] fill_r;
  logic [CntBits-1:0] fill_nxt;

  // Chain wiring; index WINDOW_MAX is the empty slot to the right of the
  // last cell.
  logic                          valid_w [WINDOW_MAX+1];
  logic signed [SAMPLE_BITS-1:0] value_w [WINDOW_MAX+1];
  logic        [PosBits-1:0]     posc_w  [WINDOW_MAX+1];
  logic                          keep_w  [WINDOW_MAX+1];

  swm_pkg::cell_ctrl_t ctrl;

  logic [CntBits-1:0]            win_len;
  logic [PosBits-1:0]            win_len_ext;
  logic [PosBits-1:0]            age0;
  logic [PosBits-1:0]            age1;
  logic                          stale0;
  logic                          stale1;
  logic                          need_shift;
  logic                          fifo_space;
  logic                          accept;
  logic [PosBits-1:0]            cur_pos;
  logic signed [SAMPLE_BITS-1:0] front_src;
  logic signed [SAMPLE_BITS-1:0] front_nxt;
  logic                          emit;

  // ------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is
  // tied high so there are no wait states.
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == swm_pkg::REG_WINDOW_LENGTH);

  always_comb begin
    wlen_nxt = cfg_write ? pwdata[swm_pkg::WLEN_BITS-1:0] : wlen_r;
    if (paddr[2] == swm_pkg::REG_WINDOW_LENGTH) begin
      prdata = {{(swm_pkg::CFG_DATA_BITS - swm_pkg::WLEN_BITS){1'b0}}, wlen_r};
    end else begin
      prdata = '0;
    end
  end

  // Effective window length: zero reads as one, oversized values are
  // clamped to the depth of the chain.
  always_comb begin
    if (wlen_r == '0) begin
      win_len = CntBits'(1);
    end else if (32'(wlen_r) > 32'(WINDOW_MAX)) begin
      win_len = CntBits'(WINDOW_MAX);
    end else begin
      win_len = CntBits'(wlen_r);
    end
    win_len_ext = PosBits'(win_len);
  end

  // ------------------------------------------------------------------
  // Stale front candidates. Positions only grow from front to back, so a
  // stale second cell implies a stale first cell. One stale front entry is
  // dropped together with the append; a second one needs a shift cycle.
  // ------------------------------------------------------------------
  always_comb begin
    age0       = pos_r - posc_w[0];
    age1       = pos_r - posc_w[1];
    stale0     = valid_w[0] && (age0 >= win_len_ext);
    stale1     = valid_w[1] && (age1 >= win_len_ext);
    need_shift = stale0 && stale1;
  end

  assign in_ready = !need_shift && fifo_space;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctrl.step  = accept;
    ctrl.clear = accept && in_sequence_start;
    ctrl.shift = need_shift || (accept && stale0);
    cur_pos    = in_sequence_start ? '0 : pos_r;
  end

  // ------------------------------------------------------------------
  // Candidate chain.
  // ------------------------------------------------------------------
  assign keep_w[0]           = 1'b1;
  assign valid_w[WINDOW_MAX] = 1'b0;
  assign value_w[WINDOW_MAX] = '0;
  assign posc_w[WINDOW_MAX]  = '0;

  for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .sample_i     (in_sample),
      .pos_i        (cur_pos),
      .keep_left_i  (keep_w[gi]),
      .right_valid_i(valid_w[gi+1]),
      .right_value_i(value_w[gi+1]),
      .right_pos_i  (posc_w[gi+1]),
      .valid_o      (valid_w[gi]),
      .value_o      (value_w[gi]),
      .pos_o        (posc_w[gi]),
      .keep_o       (keep_w[gi+1])
    );
  end

  // The new front value: the first cell either keeps what it holds (or
  // took from its neighbor) or receives the new sample.
  always_comb begin
    front_src = stale0 ? value_w[1] : value_w[0];
    front_nxt = keep_w[1] ? front_src : in_sample;
  end

  // ------------------------------------------------------------------
  // Position and fill counters. The fill count saturates at WINDOW_MAX.
  // ------------------------------------------------------------------
  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    if (accept) begin
      pos_nxt = cur_pos + PosBits'(1);
      if (in_sequence_start) begin
        fill_nxt = CntBits'(1);
      end else if (fill_r != CntBits'(WINDOW_MAX)) begin
        fill_nxt = fill_r + CntBits'(1);
      end
    end
    emit = accept && (fill_nxt >= win_len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= swm_pkg::WLEN_BITS'(1);
      pos_r  <= '0;
      fill_r <= '0;
    end else begin
      wlen_r <= wlen_nxt;
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Result buffer.
  // ------------------------------------------------------------------
  swm_out_fifo #(
    .WIDTH(SAMPLE_BITS)
  ) u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (emit),
    .data_i (front_nxt),
    .space_o(fifo_space),
    .valid_o(out_valid),
    .data_o (out_window_max),
    .ready_i(out_ready)
  );

endmodule

`default_nettype wire
